// ===== rtl/circular_deque_defines.svh =====
// Assertion macros for the circular deque RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define CD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");
`else
`define CD_ASSERT(label, clk, rst, prop)
`define CD_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/cd_pkg.sv =====
// Shared types, constants and index helpers for the circular deque.
// No dependencies.
`default_nettype none
package cd_pkg;
   localparam int MAX_DEPTH  = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(MAX_DEPTH);
   localparam int VAL_W      = 32;
   localparam int CAP_W      = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [DATA_WIDTH-1:0] store_type;
   typedef logic [VAL_W-1:0]      val_type;

   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   function automatic idx_type idx_inc(idx_type x, idx_type last);
      return (x == last) ? '0 : idx_type'(x + idx_type'(1));
   endfunction

   function automatic idx_type idx_dec(idx_type x, idx_type last);
      return (x == '0) ? last : idx_type'(x - idx_type'(1));
   endfunction

   function automatic store_type to_store(val_type v);
      logic [VAL_W+DATA_WIDTH-1:0] wide;
      wide = {{DATA_WIDTH{1'b0}}, v};
      return wide[DATA_WIDTH-1:0];
   endfunction

   function automatic val_type from_store(store_type d);
      logic [VAL_W+DATA_WIDTH-1:0] wide;
      wide = {{VAL_W{1'b0}}, d};
      return wide[VAL_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/cd_if.sv =====
// Request and response channel interfaces for the circular deque.
// Depends on cd_pkg.
`default_nettype none
interface cd_req_if import cd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic signed [VAL_W-1:0] push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface cd_rsp_if import cd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic signed [VAL_W-1:0] front_value;
   logic signed [VAL_W-1:0] rear_value;
   logic              now_empty;
   logic              now_full;

   modport source (output valid, output status, output front_value, output rear_value,
                   output now_empty, output now_full, input ready);
   modport sink   (input valid, input status, input front_value, input rear_value,
                   input now_empty, input now_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/cd_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module cd_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/circular_deque.sv =====
// Circular deque: push and pop at both ends of a RAM-held ring.
// Result registered in the cycle after accept, but a pop that leaves entries first reads
// the new end value from the RAM in S_FETCH. Throughput: 1 item/cycle for pushes and for
// pops that fail or empty the deque while results are taken; none accepted in S_FETCH.
// Reset: empty, capacity 128; RAM contents undefined, no clearing pass.
// Depends on cd_pkg, cd_if, cd_ram and circular_deque_defines.svh.
`default_nettype none
`include "circular_deque_defines.svh"
module circular_deque import cd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   cd_req_if.sink                  req_chan,
   cd_rsp_if.source                rsp_chan,
   input  wire logic               csr_write_en,
   input  wire logic [CAP_W-1:0]   csr_write_data
);
   localparam val_type ALL_ONES = {VAL_W{1'b1}};

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   idx_type          head_ff, head_in;
   idx_type          tail_ff, tail_in;
   logic             empty_ff, empty_in;
   val_type          front_ff, front_in;
   val_type          rear_ff, rear_in;
   logic             fetch_front_ff, fetch_front_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   val_type          rsp_front_ff, rsp_front_in;
   val_type          rsp_rear_ff, rsp_rear_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_full_ff, rsp_full_in;

   idx_type   cap_last;
   logic      take;
   logic      full_cur;
   logic      need_fetch;
   status_type status;
   val_type   push_val;
   logic      wr_en;
   idx_type   wr_addr;
   store_type wr_data;
   logic      rd_en;
   idx_type   rd_addr;
   store_type rd_data;

   always_comb begin
      if (cap_ff == '0) begin
         cap_last = '0;
      end else if (32'(cap_ff) > 32'(MAX_DEPTH)) begin
         cap_last = idx_type'(MAX_DEPTH - 1);
      end else begin
         cap_last = idx_type'(32'(cap_ff) - 32'd1);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign take           = req_chan.valid && req_chan.ready;
   assign full_cur       = !empty_ff && (idx_inc(tail_ff, cap_last) == head_ff);
   assign push_val       = from_store(to_store(val_type'(req_chan.push_value)));

   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      front_in       = front_ff;
      rear_in        = rear_ff;
      fetch_front_in = fetch_front_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_rear_in    = rsp_rear_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      status         = STATUS_DONE;
      need_fetch     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = head_ff;
      wr_data        = to_store(val_type'(req_chan.push_value));
      rd_en          = 1'b0;
      rd_addr        = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (mode_type'(req_chan.mode))
                  MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                     if (full_cur) begin
                        status = STATUS_OVERFLOW;
                     end else if (empty_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        empty_in = 1'b0;
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        front_in = push_val;
                        rear_in  = push_val;
                     end else if (mode_type'(req_chan.mode) == MODE_PUSH_FRONT) begin
                        head_in  = idx_dec(head_ff, cap_last);
                        wr_en    = 1'b1;
                        wr_addr  = head_in;
                        front_in = push_val;
                     end else begin
                        tail_in  = idx_inc(tail_ff, cap_last);
                        wr_en    = 1'b1;
                        wr_addr  = tail_in;
                        rear_in  = push_val;
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_REAR: begin
                     if (empty_ff) begin
                        status = STATUS_UNDERFLOW;
                     end else if (head_ff == tail_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        empty_in = 1'b1;
                     end else if (mode_type'(req_chan.mode) == MODE_POP_FRONT) begin
                        head_in        = idx_inc(head_ff, cap_last);
                        rd_en          = 1'b1;
                        rd_addr        = head_in;
                        need_fetch     = 1'b1;
                        fetch_front_in = 1'b1;
                     end else begin
                        tail_in        = idx_dec(tail_ff, cap_last);
                        rd_en          = 1'b1;
                        rd_addr        = tail_in;
                        need_fetch     = 1'b1;
                        fetch_front_in = 1'b0;
                     end
                  end
                  default: begin
                     status = STATUS_DONE;
                  end
               endcase
               rsp_status_in = status;
               rsp_empty_in  = empty_in;
               rsp_full_in   = !empty_in && (idx_inc(tail_in, cap_last) == head_in);
               rsp_front_in  = empty_in ? ALL_ONES : front_in;
               rsp_rear_in   = empty_in ? ALL_ONES : rear_in;
               if (need_fetch) begin
                  state_in = S_FETCH;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_FETCH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (fetch_front_ff) begin
               front_in     = from_store(rd_data);
               rsp_front_in = from_store(rd_data);
            end else begin
               rear_in     = from_store(rd_data);
               rsp_rear_in = from_store(rd_data);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the deque
      if (csr_write_en) begin
         cap_in   = csr_write_data;
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      rear_ff        <= rear_in;
      fetch_front_ff <= fetch_front_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_rear_ff    <= rsp_rear_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
   end

   cd_ram #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.rear_value  = rsp_rear_ff;
   assign rsp_chan.now_empty   = rsp_empty_ff;
   assign rsp_chan.now_full    = rsp_full_ff;

   `CD_ASSERT_NEXT(a_fetch_one_cycle, clock, reset, state_ff == S_FETCH, state_ff == S_IDLE)
   `CD_ASSERT(a_empty_at_origin, clock, reset, empty_ff |-> (head_ff == '0 && tail_ff == '0))
   `CD_ASSERT(a_idx_in_range, clock, reset, (head_ff <= cap_last) && (tail_ff <= cap_last))
   `CD_ASSERT(a_empty_rsp_ones, clock, reset, (rsp_valid_ff && rsp_empty_ff) |-> (rsp_front_ff == ALL_ONES && rsp_rear_ff == ALL_ONES && !rsp_full_ff))
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for circular_deque: directed and random push/pop items
// on both ends, scored against an in-bench deque predictor across capacities.
// Depends on cd_pkg, cd_if and circular_deque from the rtl folder.
module tb_top;
   import cd_pkg::*;

   localparam int ITEMS_PER_PHASE = 125;
   localparam int NUM_PHASES      = 12;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 4;

   typedef struct {
      status_type  status;
      logic [31:0] front_value;
      logic [31:0] rear_value;
      logic        now_empty;
      logic        now_full;
   } deque_result_type;

   class deque_scoreboard;
      logic [31:0]      slots [MAX_DEPTH];
      int unsigned      head;
      int unsigned      tail;
      int unsigned      span;
      bit               vacant;
      deque_result_type awaiting [$];
      int               errors;

      function new();
         errors = 0;
         set_capacity(CAP_RESET);
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         if (cap == 0)
            span = 1;
         else if (cap > MAX_DEPTH)
            span = MAX_DEPTH;
         else
            span = cap;
         head   = 0;
         tail   = 0;
         vacant = 1'b1;
      endfunction

      function bit full_now();
         return !vacant && (((tail + 1) % span) == head);
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function void note_request(mode_type op, logic [31:0] value);
         deque_result_type res;
         res.status = STATUS_DONE;
         if (head >= span) head = 0;
         if (tail >= span) tail = 0;
         if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
            if (full_now()) begin
               res.status = STATUS_OVERFLOW;
            end else if (vacant) begin
               head     = 0;
               tail     = 0;
               vacant   = 1'b0;
               slots[0] = value;
            end else if (op == MODE_PUSH_FRONT) begin
               head        = (head == 0) ? span - 1 : head - 1;
               slots[head] = value;
            end else begin
               tail        = (tail == span - 1) ? 0 : tail + 1;
               slots[tail] = value;
            end
         end else begin
            if (vacant) begin
               res.status = STATUS_UNDERFLOW;
            end else if (head == tail) begin
               head   = 0;
               tail   = 0;
               vacant = 1'b1;
            end else if (op == MODE_POP_FRONT) begin
               head = (head == span - 1) ? 0 : head + 1;
            end else begin
               tail = (tail == 0) ? span - 1 : tail - 1;
            end
         end
         res.front_value = vacant ? '1 : slots[head];
         res.rear_value  = vacant ? '1 : slots[tail];
         res.now_empty   = vacant;
         res.now_full    = full_now();
         awaiting.push_back(res);
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] front_value,
                                 logic [31:0] rear_value, logic now_empty, logic now_full);
         deque_result_type want;
         if (awaiting.size() == 0) begin
            $error("result item with nothing outstanding");
            errors++;
            return;
         end
         want = awaiting.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (front_value !== want.front_value) begin
            $error("front_value: expected %h, got %h", want.front_value, front_value);
            errors++;
         end
         if (rear_value !== want.rear_value) begin
            $error("rear_value: expected %h, got %h", want.rear_value, rear_value);
            errors++;
         end
         if (now_empty !== want.now_empty) begin
            $error("now_empty: expected %b, got %b", want.now_empty, now_empty);
            errors++;
         end
         if (now_full !== want.now_full) begin
            $error("now_full: expected %b, got %b", want.now_full, now_full);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [CAP_W-1:0] csr_write_data;
   bit               hold_rsp = 1'b0;

   deque_scoreboard sb = new();

   cd_req_if req_chan();
   cd_rsp_if rsp_chan();

   circular_deque i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("circular_deque verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // item monitor and result checker
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_request(mode_type'(req_chan.mode), req_chan.push_value);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.status, rsp_chan.front_value, rsp_chan.rear_value,
                         rsp_chan.now_empty, rsp_chan.now_full);
   end

   // result-side backpressure
   initial begin
      int gap;
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat (($urandom_range(0, 9) < 2) ? $urandom_range(20, 60) : $urandom_range(1, 6))
               @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   task automatic send_item(mode_type op, logic [31:0] value, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= op;
      req_chan.push_value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_for_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= cap;
      sb.set_capacity(cap);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CAP_W-1:0] caps [NUM_PHASES];
      int               done_items;
      int               streak;
      int               push_bias;
      bit               quiet;
      mode_type         op;

      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_PUSH_FRONT;
      req_chan.push_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: underflow at both ends, front wraps both ways, a last-entry pop
      send_item(MODE_POP_FRONT,  32'h0, pick_gap());
      send_item(MODE_POP_REAR,   32'h0, pick_gap());
      send_item(MODE_PUSH_FRONT, 32'h7FFF_FFFF, pick_gap());
      send_item(MODE_PUSH_FRONT, 32'h8000_0000, pick_gap());
      send_item(MODE_PUSH_REAR,  32'h0000_0000, pick_gap());
      send_item(MODE_PUSH_REAR,  32'hFFFF_FFFF, pick_gap());
      send_item(MODE_POP_FRONT,  32'hFFFF_FFFF, pick_gap());
      send_item(MODE_POP_REAR,   32'h1234_5678, pick_gap());
      send_item(MODE_POP_FRONT,  32'h0, pick_gap());
      send_item(MODE_POP_REAR,   32'h0, pick_gap());
      send_item(MODE_POP_FRONT,  32'h0, pick_gap());

      // single entry: full after one push, overflow at both ends
      write_capacity(8'd1);
      send_item(MODE_PUSH_REAR,  32'hA5A5_A5A5, 0);
      send_item(MODE_PUSH_FRONT, 32'h5A5A_5A5A, 0);
      send_item(MODE_PUSH_REAR,  32'h5A5A_5A5A, 0);
      send_item(MODE_POP_REAR,   32'h0, 0);
      send_item(MODE_PUSH_FRONT, 32'h5A5A_5A5A, 0);
      send_item(MODE_POP_FRONT,  32'h0, 0);

      // two entries: overflow at the front, rear wraps both ways
      write_capacity(8'd2);
      send_item(MODE_PUSH_REAR,  32'h0000_0001, 0);
      send_item(MODE_PUSH_REAR,  32'h0000_0002, 0);
      send_item(MODE_PUSH_FRONT, 32'h0000_0003, 0);
      send_item(MODE_POP_FRONT,  32'h0, 0);
      send_item(MODE_PUSH_REAR,  32'h0000_0004, 0);
      send_item(MODE_POP_REAR,   32'h0, 0);

      caps = '{8'd128, 8'd1, 8'd2, 8'd0, 8'd255, 8'd5, 8'd128, 8'd16,
               8'($urandom_range(3, 127)), 8'd129, 8'($urandom_range(3, 127)), 8'd127};

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_capacity(caps[phase]);
         if (phase == 4 || phase == 6)
            hold_rsp = 1'b1;
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 2))
               0: push_bias = 85;
               1: push_bias = 50;
               default: push_bias = 15;
            endcase
            quiet  = ($urandom_range(0, 3) == 0);
            streak = $urandom_range(1, 2 * sb.span + 4);
            for (int k = 0; k < streak && done_items < ITEMS_PER_PHASE; k++) begin
               if ($urandom_range(0, 99) < push_bias)
                  op = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
               else
                  op = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
               send_item(op, pick_value(), quiet ? 0 : pick_gap());
               done_items++;
               if ($urandom_range(0, 199) == 0)
                  wait_for_results();
            end
         end
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("circular_deque verification clean");
      else
         $display("circular_deque verification failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cd_pkg.sv
rtl/cd_if.sv
rtl/cd_ram.sv
rtl/circular_deque.sv
verif/tb_top.sv
